// ----- rtl/core/crfa_pkg.sv -----
// ---------------------------------------------------------------------------
// CRC framed register access: shared package
// Codes, widths, the CRC-8 byte update and the memory request structures.
// ---------------------------------------------------------------------------
package crfa_pkg;

  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned BANK_DEPTH    = 64;
  localparam int unsigned REG_COUNT_DEF = 64;

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [1:0] KIND_PLAIN = 2'b00;
  localparam logic [1:0] KIND_WRITE = 2'b01;
  localparam logic [1:0] KIND_READ  = 2'b10;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_PLAIN = 3'd2,
    PH_LEN   = 3'd3,
    PH_WDATA = 3'd4,
    PH_CRC   = 3'd5,
    PH_RDATA = 3'd6,
    PH_DROP  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_COMMIT = 3'd1,
    ST_ARMED  = 3'd2,
    ST_BADCRC = 3'd3,
    ST_BADLEN = 3'd4
  } status_e;

  // One write port and one read port of a byte-wide memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/crc_framed_register_access_unit.sv -----
// ---------------------------------------------------------------------------
// CRC framed register access unit
// Target-side byte register bank behind framed bus transactions with CRC-8.
// ---------------------------------------------------------------------------
// Each input transaction is one bus event (start, host write, host read,
// stop) and gives exactly one result transaction carrying the read byte and
// a status code. An event is taken into an input register and decoded from
// there into the output register, so one event is accepted per cycle while
// the output side keeps up. The bank read port is registered and always
// holds the byte at the current address. The one exception to that rate is
// a write frame whose CRC matches: its N staged bytes are copied into the
// bank through the single bank write port, one byte a cycle, so the next
// event waits until all N (from 1 to REG_COUNT) are copied. No clearing pass
// runs after reset.
// ---------------------------------------------------------------------------
module crc_framed_register_access_unit
  import crfa_pkg::*;
#(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic [2:0] status_o
);

  localparam logic [6:0] RegCountW = 7'(REG_COUNT);

  // Input register
  logic       s1_valid_q;
  op_e        op_q;
  logic [7:0] byte_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] rbyte_q, rbyte_d;
  status_e    status_q, status_d;

  // Frame state
  phase_e            phase_q, phase_d;
  logic [1:0]        kind_q, kind_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [6:0]        len_q, len_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [7:0]        crc_q, crc_d;
  logic              armed_q, armed_d;
  logic              commit_q, commit_d;
  logic [6:0]        swp_q, swp_d;

  logic              fire;
  logic              out_free;
  logic              addr_ok;
  logic [ADDR_W-1:0] addr_inc;
  logic [6:0]        cnt_inc;
  logic [6:0]        swp_inc;
  logic [7:0]        bank_rd;
  logic [7:0]        bank_rd_raw;
  logic [7:0]        stg_rd;
  mem_req_t          bank_req;
  mem_req_t          stg_req;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && out_free && !commit_q;
  assign in_ready_o = !s1_valid_q || fire;

  assign addr_ok  = {1'b0, addr_q} < RegCountW;
  assign addr_inc = (({1'b0, addr_q} + 7'd1) >= RegCountW) ? '0 : addr_q + 1'b1;
  assign cnt_inc  = cnt_q + 7'd1;
  assign swp_inc  = swp_q + 7'd1;
  assign bank_rd  = addr_ok ? bank_rd_raw : 8'hFF;

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    addr_d   = addr_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    armed_d  = armed_q;
    commit_d = commit_q;
    swp_d    = swp_q;
    rbyte_d  = '0;
    status_d = ST_NONE;

    bank_req.we    = 1'b0;
    bank_req.waddr = addr_q;
    bank_req.wdata = byte_q;
    stg_req.we     = 1'b0;
    stg_req.waddr  = cnt_q[ADDR_W-1:0];
    stg_req.wdata  = byte_q;

    if (commit_q) begin
      // Copy one staged byte per cycle into the bank.
      bank_req.we    = addr_ok;
      bank_req.wdata = stg_rd;
      addr_d         = addr_inc;
      swp_d          = swp_inc;
      if (swp_inc >= len_q) begin
        commit_d = 1'b0;
      end
    end else if (fire) begin
      case (op_q)
        OP_START: begin
          phase_d = armed_q ? PH_RDATA : PH_CMD;
        end
        OP_STOP: begin
          phase_d = PH_IDLE;
          armed_d = 1'b0;
        end
        OP_WRITE: begin
          case (phase_q)
            PH_CMD: begin
              addr_d = byte_q[ADDR_W-1:0];
              kind_d = byte_q[7:6];
              crc_d  = crc8_byte(8'h00, byte_q);
              case (byte_q[7:6])
                KIND_PLAIN:            phase_d = PH_PLAIN;
                KIND_WRITE, KIND_READ: phase_d = PH_LEN;
                default:               phase_d = PH_DROP;
              endcase
            end
            PH_PLAIN: begin
              bank_req.we = addr_ok;
              addr_d      = addr_inc;
              status_d    = ST_COMMIT;
            end
            PH_LEN: begin
              crc_d = crc8_byte(crc_q, byte_q);
              if ((byte_q == 8'h00) || (byte_q > {1'b0, RegCountW})) begin
                phase_d  = PH_DROP;
                status_d = ST_BADLEN;
              end else begin
                len_d   = byte_q[6:0];
                cnt_d   = '0;
                phase_d = (kind_q == KIND_WRITE) ? PH_WDATA : PH_CRC;
              end
            end
            PH_WDATA: begin
              stg_req.we = 1'b1;
              crc_d      = crc8_byte(crc_q, byte_q);
              cnt_d      = cnt_inc;
              if (cnt_inc >= len_q) begin
                phase_d = PH_CRC;
              end
            end
            PH_CRC: begin
              if (byte_q != crc_q) begin
                phase_d  = PH_DROP;
                status_d = ST_BADCRC;
              end else if (kind_q == KIND_WRITE) begin
                commit_d = 1'b1;
                swp_d    = '0;
                phase_d  = PH_DROP;
                status_d = ST_COMMIT;
              end else begin
                armed_d  = 1'b1;
                cnt_d    = '0;
                phase_d  = PH_RDATA;
                status_d = ST_ARMED;
              end
            end
            PH_RDATA: begin
              armed_d = 1'b0;
              phase_d = PH_DROP;
            end
            default: begin
            end
          endcase
        end
        OP_READ: begin
          case (phase_q)
            PH_CMD, PH_PLAIN: begin
              phase_d = PH_PLAIN;
              rbyte_d = bank_rd;
              addr_d  = addr_inc;
            end
            PH_RDATA: begin
              if (cnt_q < len_q) begin
                rbyte_d = bank_rd;
                addr_d  = addr_inc;
                crc_d   = crc8_byte(crc_q, bank_rd);
                cnt_d   = cnt_inc;
              end else begin
                // The trailing byte of a read is the running CRC.
                armed_d = 1'b0;
                phase_d = PH_DROP;
                rbyte_d = crc_q;
              end
            end
            PH_LEN, PH_WDATA, PH_CRC: begin
              phase_d = PH_DROP;
              rbyte_d = 8'hFF;
            end
            default: begin
              rbyte_d = 8'hFF;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // The bank read port follows the next address; the staging read port
    // follows the next copy index.
    bank_req.raddr = addr_d;
    stg_req.raddr  = swp_d[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_e'(op_i);
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rbyte_q  <= rbyte_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      kind_q   <= '0;
      addr_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      crc_q    <= '0;
      armed_q  <= 1'b0;
      commit_q <= 1'b0;
      swp_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      addr_q   <= addr_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      armed_q  <= armed_d;
      commit_q <= commit_d;
      swp_q    <= swp_d;
    end
  end

  crfa_bank u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bank_req),
    .rd_data_o (bank_rd_raw)
  );

  crfa_stage_buf u_stage_buf (
    .clk_i     (clk_i),
    .req_i     (stg_req),
    .rd_data_o (stg_rd)
  );

  assign out_valid_o = out_valid_q;
  assign read_byte_o = rbyte_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/core/crfa_bank.sv -----
// ---------------------------------------------------------------------------
// CRC framed register access: register bank
// Byte memory with per-entry valid bits so that reset reads as zero. The
// read port is registered and forwards a write to the same address.
// ---------------------------------------------------------------------------
module crfa_bank
  import crfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]            mem [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] valid_q;
  logic [7:0]            rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rd_q <= req_i.wdata;
    end else if (valid_q[req_i.raddr]) begin
      rd_q <= mem[req_i.raddr];
    end else begin
      rd_q <= '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/core/crfa_stage_buf.sv -----
// ---------------------------------------------------------------------------
// CRC framed register access: staging buffer
// Holds the data bytes of a write frame until its CRC has been checked.
// ---------------------------------------------------------------------------
module crfa_stage_buf
  import crfa_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [BANK_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  assign rd_data_o = rd_q;

endmodule

// ----- verif/crc_framed_register_access_unit_test.sv -----
// ---------------------------------------------------------------------------
// CRC framed register access unit: self-checking testbench
// Drives framed bus events (start, host write, host read, stop) into the unit
// and checks every returned read byte and status against a behavioural
// model of the register bank, the frame decoder and the CRC-8 checks.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

import crfa_pkg::*;

// CRC-8, polynomial 0x07, shifted in one message bit at a time, MSB first.
function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
  logic [7:0] c;
  c = crc;
  for (int k = 7; k >= 0; k--) begin
    if (c[7] ^ b[k]) begin
      c = {c[6:0], 1'b0} ^ CRC_POLY;
    end else begin
      c = {c[6:0], 1'b0};
    end
  end
  return c;
endfunction

class access_scoreboard;

  typedef struct packed {
    logic [7:0] read_byte;
    status_e    status;
  } reply_t;

  reply_t expected_replies[$];
  int     failures;

  // Model state of the target.
  logic [7:0] bank [BANK_DEPTH];
  logic [7:0] staging [BANK_DEPTH];
  phase_e     phase;
  logic [1:0] kind;
  logic [5:0] addr;
  logic [6:0] flen;
  logic [6:0] bcnt;
  logic [7:0] crc;
  bit         armed;

  function new();
    foreach (bank[k]) bank[k] = 8'h00;
    foreach (staging[k]) staging[k] = 8'h00;
    phase    = PH_IDLE;
    kind     = KIND_PLAIN;
    addr     = '0;
    flen     = '0;
    bcnt     = '0;
    crc      = 8'h00;
    armed    = 1'b0;
    failures = 0;
  endfunction

  function logic [5:0] step_addr(logic [5:0] a);
    return (int'(a) + 1 >= REG_COUNT_DEF) ? 6'd0 : a + 6'd1;
  endfunction

  function logic [7:0] fetch(logic [5:0] a);
    return (int'(a) < REG_COUNT_DEF) ? bank[a] : 8'hFF;
  endfunction

  function void store(logic [5:0] a, logic [7:0] v);
    if (int'(a) < REG_COUNT_DEF) bank[a] = v;
  endfunction

  function status_e host_write_byte(logic [7:0] b);
    int i;
    case (phase)
      PH_CMD: begin
        addr = b[5:0];
        kind = b[7:6];
        crc  = crc8_update(8'h00, b);
        if (kind == KIND_PLAIN) begin
          phase = PH_PLAIN;
        end else if (kind == KIND_WRITE || kind == KIND_READ) begin
          phase = PH_LEN;
        end else begin
          phase = PH_DROP;
        end
        return ST_NONE;
      end
      PH_PLAIN: begin
        store(addr, b);
        addr = step_addr(addr);
        return ST_COMMIT;
      end
      PH_LEN: begin
        crc = crc8_update(crc, b);
        if (b == 8'd0 || int'(b) > REG_COUNT_DEF) begin
          phase = PH_DROP;
          return ST_BADLEN;
        end
        flen  = b[6:0];
        bcnt  = '0;
        phase = (kind == KIND_WRITE) ? PH_WDATA : PH_CRC;
        return ST_NONE;
      end
      PH_WDATA: begin
        staging[bcnt[5:0]] = b;
        crc  = crc8_update(crc, b);
        bcnt = bcnt + 7'd1;
        if (bcnt >= flen) phase = PH_CRC;
        return ST_NONE;
      end
      PH_CRC: begin
        if (b != crc) begin
          phase = PH_DROP;
          return ST_BADCRC;
        end
        if (kind == KIND_WRITE) begin
          for (i = 0; i < int'(flen); i++) begin
            store(addr, staging[i]);
            addr = step_addr(addr);
          end
          phase = PH_DROP;
          return ST_COMMIT;
        end
        armed = 1'b1;
        bcnt  = '0;
        phase = PH_RDATA;
        return ST_ARMED;
      end
      PH_RDATA: begin
        // A host write during an armed read abandons it.
        armed = 1'b0;
        phase = PH_DROP;
        return ST_NONE;
      end
      default: return ST_NONE;
    endcase
  endfunction

  function logic [7:0] host_read_byte();
    logic [7:0] v;
    case (phase)
      PH_CMD, PH_PLAIN: begin
        phase = PH_PLAIN;
        v     = fetch(addr);
        addr  = step_addr(addr);
        return v;
      end
      PH_RDATA: begin
        if (bcnt < flen) begin
          v    = fetch(addr);
          addr = step_addr(addr);
          crc  = crc8_update(crc, v);
          bcnt = bcnt + 7'd1;
          return v;
        end
        // The byte after the data is the CRC carried on from the request through the data.
        armed = 1'b0;
        phase = PH_DROP;
        return crc;
      end
      PH_LEN, PH_WDATA, PH_CRC: begin
        phase = PH_DROP;
        return 8'hFF;
      end
      default: return 8'hFF;
    endcase
  endfunction

  // Called for every accepted input transaction.
  function void note_event(op_e op, logic [7:0] b);
    reply_t r;
    r.read_byte = 8'h00;
    r.status    = ST_NONE;
    case (op)
      OP_START: phase = armed ? PH_RDATA : PH_CMD;
      OP_WRITE: r.status = host_write_byte(b);
      OP_READ:  r.read_byte = host_read_byte();
      default: begin
        phase = PH_IDLE;
        armed = 1'b0;
      end
    endcase
    expected_replies.push_back(r);
  endfunction

  function void report(string field, logic [7:0] exp_val, logic [7:0] act_val);
    failures++;
    $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, exp_val,
             act_val);
  endfunction

  // Called for every accepted result transaction.
  function void check_reply(logic [7:0] rb, logic [2:0] st);
    reply_t e;
    if (expected_replies.size() == 0) begin
      failures++;
      $display("%0t: result with nothing outstanding, expected none, actual %02h/%0d",
               $time, rb, st);
      return;
    end
    e = expected_replies.pop_front();
    if (rb !== e.read_byte) report("read_byte", e.read_byte, rb);
    if (st !== e.status) report("status", 8'(e.status), 8'(st));
  endfunction

endclass

module crc_framed_register_access_unit_test;

  localparam int RANDOM_EVENTS = 750;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 100;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_CRC,
    FLAW_JAM,
    FLAW_BAD_LEN,
    FLAW_READ_MID,
    FLAW_RESTART
  } frame_flaw_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] op_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] read_byte_o;
  logic [2:0] status_o;

  access_scoreboard replies = new();

  int events_sent;
  int cycle_count;
  bit sender_idle;
  bit receiver_idle;
  bit hold_request;

  crc_framed_register_access_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_byte_o (read_byte_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Both handshakes are observed at the rising edge; inputs were set up at
  // the preceding falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) replies.note_event(op_e'(op_i), data_byte_i);
      if (out_valid_o && out_ready_i) replies.check_reply(read_byte_o, status_o);
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(200, 400)) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Offers one transaction and returns at the falling edge after acceptance.
  task automatic send_event(op_e op, logic [7:0] b);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    events_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (replies.expected_replies.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] flip_bit(logic [7:0] v);
    return v ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] bad_length();
    return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(REG_COUNT_DEF + 1, 255));
  endfunction

  // Mostly short frames; now and then one up to the full bank.
  function automatic int frame_length();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(9, REG_COUNT_DEF)
                                        : $urandom_range(1, 8);
  endfunction

  task automatic finish_frame();
    if ($urandom_range(0, 3) != 0) send_event(OP_STOP, 8'($urandom));
  endtask

  task automatic write_frame(logic [5:0] a, int len, frame_flaw_e flaw);
    logic [7:0] c;
    logic [7:0] cmd;
    logic [7:0] d;
    cmd = {KIND_WRITE, a};
    // The jammed variant seeds the CRC with all ones, which the target refuses.
    c = (flaw == FLAW_JAM) ? 8'hFF : 8'h00;
    send_event(OP_START, 8'($urandom));
    send_event(OP_WRITE, cmd);
    c = crc8_update(c, cmd);
    if (flaw == FLAW_BAD_LEN) begin
      send_event(OP_WRITE, bad_length());
      repeat ($urandom_range(0, 3)) send_event(OP_WRITE, 8'($urandom));
      finish_frame();
      return;
    end
    send_event(OP_WRITE, 8'(len));
    c = crc8_update(c, 8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == len / 2 && flaw == FLAW_READ_MID) begin
        send_event(OP_READ, 8'($urandom));
        finish_frame();
        return;
      end
      if (i == len / 2 && flaw == FLAW_RESTART) begin
        send_event(OP_START, 8'($urandom));
        finish_frame();
        return;
      end
      d = 8'($urandom);
      send_event(OP_WRITE, d);
      c = crc8_update(c, d);
    end
    send_event(OP_WRITE, (flaw == FLAW_BAD_CRC) ? flip_bit(c) : c);
    finish_frame();
  endtask

  task automatic read_request(logic [5:0] a, int len, frame_flaw_e flaw);
    logic [7:0] c;
    logic [7:0] cmd;
    int reads;
    cmd = {KIND_READ, a};
    c   = (flaw == FLAW_JAM) ? 8'hFF : 8'h00;
    send_event(OP_START, 8'($urandom));
    send_event(OP_WRITE, cmd);
    c = crc8_update(c, cmd);
    if (flaw == FLAW_BAD_LEN) begin
      send_event(OP_WRITE, bad_length());
    end else begin
      send_event(OP_WRITE, 8'(len));
      c = crc8_update(c, 8'(len));
      if (flaw == FLAW_READ_MID) send_event(OP_READ, 8'($urandom));
      send_event(OP_WRITE, (flaw == FLAW_BAD_CRC) ? flip_bit(c) : c);
    end
    // Normally the data and its CRC byte; sometimes short or overlong.
    reads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len + 2) : len + 1;
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(0, 9) == 0) send_event(OP_START, 8'($urandom));
      send_event(OP_READ, 8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) send_event(OP_WRITE, 8'($urandom));
    finish_frame();
  endtask

  task automatic plain_access(logic [5:0] a);
    send_event(OP_START, 8'($urandom));
    send_event(OP_WRITE, {KIND_PLAIN, a});
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 5) == 0) send_event(OP_START, 8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        send_event(OP_READ, 8'($urandom));
      end else begin
        send_event(OP_WRITE, 8'($urandom));
      end
    end
    finish_frame();
  endtask

  initial begin
    int  pick;
    bit  hold_done;
    bit  pause_done;
    int  target;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_START;
    data_byte_i   = 8'h00;
    events_sent   = 0;
    cycle_count   = 0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Plain writes at the top of the bank, wrapping back to address zero.
    send_event(OP_START, 8'h00);
    send_event(OP_WRITE, {KIND_PLAIN, 6'h3E});
    send_event(OP_WRITE, 8'hFF);
    send_event(OP_WRITE, 8'h00);
    // A read straight after a start uses the current address.
    send_event(OP_START, 8'hFF);
    send_event(OP_READ, 8'h00);
    send_event(OP_STOP, 8'h00);
    // Idle bus: reads give all ones, writes are ignored.
    send_event(OP_READ, 8'hA5);
    send_event(OP_WRITE, 8'h5A);
    // Command kind with no meaning drops the frame.
    send_event(OP_START, 8'h00);
    send_event(OP_WRITE, 8'hC7);
    send_event(OP_WRITE, 8'h12);
    send_event(OP_READ, 8'h00);
    // Zero length and a length beyond the register count.
    send_event(OP_START, 8'h00);
    send_event(OP_WRITE, {KIND_WRITE, 6'h00});
    send_event(OP_WRITE, 8'h00);
    send_event(OP_START, 8'h00);
    send_event(OP_WRITE, {KIND_READ, 6'h00});
    send_event(OP_WRITE, 8'(REG_COUNT_DEF + 1));
    send_event(OP_STOP, 8'h00);
    write_frame(6'h3F, 1, FLAW_NONE);

    target = events_sent + RANDOM_EVENTS;
    while (events_sent < target) begin
      sender_idle   = !(events_sent > 150 && events_sent < 250) &&
                      events_sent < target - 150;
      receiver_idle = sender_idle;
      if (!hold_done && events_sent > 320) begin
        // The sender keeps offering while results are held back.
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && events_sent > 450) begin
        wait_for_drain();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        write_frame(6'($urandom), frame_length(), FLAW_NONE);
      end else if (pick < 55) begin
        read_request(6'($urandom), frame_length(), FLAW_NONE);
      end else if (pick < 65) begin
        plain_access(6'($urandom));
      end else if (pick < 75) begin
        write_frame(6'($urandom), frame_length(),
                    frame_flaw_e'($urandom_range(FLAW_BAD_CRC, FLAW_RESTART)));
      end else if (pick < 85) begin
        read_request(6'($urandom), frame_length(),
                     frame_flaw_e'($urandom_range(FLAW_BAD_CRC, FLAW_READ_MID)));
      end else begin
        repeat ($urandom_range(1, 6)) send_event(op_e'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (replies.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
